// File: src/sem_pkg.sv
// Shared types and helpers for the Sobel edge magnitude block.
// Used by the front end, the queue, the back end and the top level.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int unsigned PixW   = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned GradW  = 11;
  localparam int unsigned SumW   = 22;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HeightW = 12;
  localparam int unsigned RowW   = 13;
  // Largest sum of squares that still rounds below 256: 255*255 + 255
  localparam logic [SumW-1:0] SatLimit = 22'd65280;

  // Register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // One masked 3x3 window plus its position flags
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic                 eol;
    logic                 eof;
  } sem_item_t;

  function automatic logic [ChanW-1:0] sem_chan(input logic [PixW-1:0] p, input int ch);
    logic [ChanW-1:0] v;
    v = p[PixW-1-ChanW*ch -: ChanW];
    return v;
  endfunction

  // Sobel X: -w0 + w2 - 2w3 + 2w5 - w6 + w8
  function automatic logic signed [GradW-1:0] sem_gx(input logic [8:0][PixW-1:0] w,
                                                     input int ch);
    logic signed [GradW-1:0] a;
    a = $signed({3'b0, sem_chan(w[2], ch)}) - $signed({3'b0, sem_chan(w[0], ch)})
      + $signed({2'b0, sem_chan(w[5], ch), 1'b0}) - $signed({2'b0, sem_chan(w[3], ch), 1'b0})
      + $signed({3'b0, sem_chan(w[8], ch)}) - $signed({3'b0, sem_chan(w[6], ch)});
    return a;
  endfunction

  // Sobel Y: -w0 - 2w1 - w2 + w6 + 2w7 + w8
  function automatic logic signed [GradW-1:0] sem_gy(input logic [8:0][PixW-1:0] w,
                                                     input int ch);
    logic signed [GradW-1:0] a;
    a = $signed({3'b0, sem_chan(w[6], ch)}) - $signed({3'b0, sem_chan(w[0], ch)})
      + $signed({2'b0, sem_chan(w[7], ch), 1'b0}) - $signed({2'b0, sem_chan(w[1], ch), 1'b0})
      + $signed({3'b0, sem_chan(w[8], ch)}) - $signed({3'b0, sem_chan(w[2], ch)});
    return a;
  endfunction

endpackage

// File: src/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sem_front.sv
// Front end: accepts pixels and flush items, runs the line stores and the window,
// tracks input and output positions and queues masked windows. Uses sem_pkg, sem_ram.
`timescale 1ns / 1ps
module sem_front import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic [WidthW-1:0]  width_i,
  input  logic [HeightW-1:0] height_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [PixW-1:0]    pix_i,
  input  logic               flush_i,
  input  logic               full_i,
  output logic               push_o,
  output sem_item_t          item_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned EffW = $clog2(MAX_WIDTH + 1) > WidthW ?
                                 $clog2(MAX_WIDTH + 1) : WidthW;
  localparam logic [EffW-1:0] MaxW = EffW'(MAX_WIDTH);

  localparam logic FS_IDLE = 1'b0;
  localparam logic FS_READ = 1'b1;

  logic                 state_q, state_d;
  logic [ColW-1:0]      in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]      in_row_q, in_row_d, out_row_q, out_row_d;
  logic [8:0][PixW-1:0] win_q, win_d, win_n;
  logic [PixW-1:0]      pix_q;
  logic [PixW-1:0]      top, mid;
  logic [EffW-1:0]      wid;
  logic [RowW-1:0]      hgt;
  logic                 complete, fire, primed, eol, eof;
  logic                 row0_off, row2_off, col0_off, col2_off;

  // Clamp configured sizes
  always_comb begin
    if (width_i == '0) begin
      wid = EffW'(1);
    end else if (EffW'(width_i) > MaxW) begin
      wid = MaxW;
    end else begin
      wid = EffW'(width_i);
    end
    hgt = (height_i == '0) ? RowW'(1) : RowW'(height_i);
  end

  assign complete = in_row_q >= hgt;
  assign ready_o  = (state_q == FS_IDLE) && !full_i;
  assign fire     = valid_i && ready_o && !(flush_i && !complete);

  // Line stores
  sem_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_upper (
    .clk_i, .we_i(state_q == FS_READ), .waddr_i(in_col_q), .wdata_i(mid),
    .raddr_i(in_col_q), .rdata_o(top)
  );
  sem_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_middle (
    .clk_i, .we_i(state_q == FS_READ), .waddr_i(in_col_q), .wdata_i(pix_q),
    .raddr_i(in_col_q), .rdata_o(mid)
  );

  // Shifted window and edge masks
  always_comb begin
    win_n    = win_q;
    win_n[0] = win_q[1];
    win_n[1] = win_q[2];
    win_n[2] = top;
    win_n[3] = win_q[4];
    win_n[4] = win_q[5];
    win_n[5] = mid;
    win_n[6] = win_q[7];
    win_n[7] = win_q[8];
    win_n[8] = pix_q;
    row0_off = out_row_q == '0;
    row2_off = (out_row_q + RowW'(1)) >= hgt;
    col0_off = out_col_q == '0;
    col2_off = (EffW'(out_col_q) + EffW'(1)) >= wid;
    eol      = col2_off;
    eof      = eol && row2_off;
    primed   = (in_row_q >= RowW'(2)) || (in_row_q == RowW'(1) && in_col_q != '0);
    item_o.win = win_n;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if ((r == 0 && row0_off) || (r == 2 && row2_off) ||
            (k == 0 && col0_off) || (k == 2 && col2_off)) begin
          item_o.win[r*3+k] = '0;
        end
      end
    end
    item_o.eol = eol;
    item_o.eof = eof;
  end

  assign push_o = (state_q == FS_READ) && primed;

  // Sequencing and counters
  always_comb begin
    state_d   = state_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    win_d     = win_q;
    if (restart_i) begin
      state_d   = FS_IDLE;
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      win_d     = '0;
    end else if (state_q == FS_IDLE) begin
      if (fire) begin
        state_d = FS_READ;
      end
    end else begin
      state_d = FS_IDLE;
      win_d   = win_n;
      if ((EffW'(in_col_q) + EffW'(1)) >= wid) begin
        in_col_d = '0;
        in_row_d = in_row_q + RowW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (primed) begin
        if (eof) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          win_d     = '0;
        end else if (eol) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FS_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      win_q     <= '0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      win_q     <= win_d;
    end
  end

  // Pixel held for the write-back cycle; zero once the frame is complete
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pix_q <= complete ? '0 : pix_i;
    end
  end

endmodule

// File: src/sem_fifo.sv
// Two-entry queue of windows between the front and back ends.
// Uses sem_pkg.
`timescale 1ns / 1ps
module sem_fifo import sem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sem_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output sem_item_t item_o
);

  sem_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: src/sem_back.sv
// Back end: Sobel gradients, sum of squares, bit-serial rounded square root
// and the output register. Uses sem_pkg.
`timescale 1ns / 1ps
module sem_back import sem_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sem_item_t       item_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [PixW-1:0] data_o,
  output logic            eol_o,
  output logic            eof_o
);

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_SQ   = 2'd1;
  localparam logic [1:0] BS_ROOT = 2'd2;
  localparam logic [1:0] BS_OUT  = 2'd3;

  logic [1:0]              state_q;
  logic [2:0]              bit_q;
  logic signed [GradW-1:0] gx_q [3];
  logic signed [GradW-1:0] gy_q [3];
  logic [SumW-1:0]         s_q [3];
  logic [ChanW-1:0]        r_q [3];
  logic                    eol_q, eof_q, valid_q;
  logic [PixW-1:0]         data_q;
  logic [ChanW-1:0]        trial [3];
  logic [ChanW-1:0]        mag [3];
  logic                    take;

  assign pop_o = (state_q == BS_IDLE) && !empty_i;
  assign take  = (state_q == BS_OUT) && (!valid_q || ready_i);

  // Trial bit and final rounding per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = r_q[ch] | ChanW'(8'd1 << bit_q);
      if (s_q[ch] > SatLimit) begin
        mag[ch] = 8'd255;
      end else if (s_q[ch] > SumW'({8'd0, r_q[ch]} * {8'd0, r_q[ch]} + {8'd0, r_q[ch]})) begin
        mag[ch] = r_q[ch] + 8'd1;
      end else begin
        mag[ch] = r_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      valid_q <= 1'b0;
      bit_q   <= 3'd7;
    end else begin
      // Output register valid: set on a new result, cleared once taken
      if (take) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
      unique case (state_q)
        BS_IDLE: if (pop_o) state_q <= BS_SQ;
        BS_SQ: begin
          bit_q   <= 3'd7;
          state_q <= BS_ROOT;
        end
        BS_ROOT: begin
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) state_q <= BS_OUT;
        end
        BS_OUT: begin
          if (take) begin
            state_q <= BS_IDLE;
          end
        end
        default: state_q <= BS_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (pop_o) begin
        gx_q[ch] <= sem_gx(item_i.win, ch);
        gy_q[ch] <= sem_gy(item_i.win, ch);
      end
      if (state_q == BS_SQ) begin
        s_q[ch] <= SumW'(gx_q[ch]) * SumW'(gx_q[ch]) + SumW'(gy_q[ch]) * SumW'(gy_q[ch]);
        r_q[ch] <= '0;
      end
      if (state_q == BS_ROOT &&
          SumW'({8'd0, trial[ch]} * {8'd0, trial[ch]}) <= s_q[ch]) begin
        r_q[ch] <= trial[ch];
      end
    end
    if (pop_o) begin
      eol_q <= item_i.eol;
      eof_q <= item_i.eof;
    end
    if (take) begin
      // red in the top byte, as in the window
      data_q <= {mag[0], mag[1], mag[2]};
      eol_o  <= eol_q;
      eof_o  <= eof_q;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude on an RGB stream. The front end handles each item as an accept
// followed by a line store write-back; the input takes a new transaction only after
// that write-back and while the queue has room. The back end works through load, square,
// 8-step bit-serial square root and output for each window, and takes the next one only
// once its result has gone into the output register.
// Reset clears counters, window and handshake state; line stores are not cleared and
// width resets to 1024, height to 1. A register write restarts the frame.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic        s_axis_tuser,   // flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  output logic        m_axis_tlast,   // end_of_line
  output logic        m_axis_tuser,   // end_of_frame
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic               wr, push, pop, full, empty;
  sem_item_t          item_in, item_out;
  logic [PixW-1:0]    data;

  // Configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegHeight) ? {20'd0, height_q} : {21'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 12'd1;
    end else if (wr) begin
      if (paddr[2] == RegWidth) width_q <= pwdata[WidthW-1:0];
      else height_q <= pwdata[HeightW-1:0];
    end
  end

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .restart_i(wr), .width_i(width_q), .height_i(height_q),
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .pix_i({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .flush_i(s_axis_tuser), .full_i(full), .push_o(push), .item_o(item_in)
  );

  sem_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(item_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(item_out)
  );

  sem_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(item_out), .pop_o(pop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(data),
    .eol_o(m_axis_tlast), .eof_o(m_axis_tuser)
  );

  // Pixel is packed red in the top byte internally; the bus carries red lowest
  assign m_axis_tdata = {data[7:0], data[15:8], data[23:16]};

endmodule

// File: dv/sem_checker.sv
// Checker for the Sobel edge magnitude block: watches the input, output and register
// channels, predicts each result pixel and compares it field by field.
// Depends on sem_pkg for the register indexes.
`timescale 1ns / 1ps
module sem_checker import sem_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  localparam int LineDepth = 1024;
  localparam int KernX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KernY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eol;
    logic       eof;
  } edge_pix_t;

  edge_pix_t   edge_q[$];
  logic [23:0] upper_line[LineDepth];
  logic [23:0] middle_line[LineDepth];
  logic [23:0] win[9];
  int unsigned frame_w, frame_h;
  int unsigned col_in, row_in, col_out, row_out;

  assign pending_o = edge_q.size();

  // Rounded square root, saturated at 255
  function automatic logic [7:0] rounded_root(input int unsigned s);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s > r * r + r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic void clear_frame();
    foreach (win[i]) win[i] = '0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
  endfunction

  // Advance the model by one pixel transaction; may queue one result
  function automatic void take_pixel(input logic [23:0] tdata, input logic flush);
    logic [23:0] pix, top, mid;
    int unsigned c;
    bit done, ready;
    int gx, gy, v;
    logic [7:0] mag[3];
    edge_pix_t e;
    done = row_in >= frame_h;
    if (!done && flush) return;
    // model keeps red in the high byte
    pix = done ? 24'd0 : {tdata[7:0], tdata[15:8], tdata[23:16]};
    c = (col_in >= LineDepth) ? 0 : col_in;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top; win[5] = mid; win[8] = pix;
    ready = row_in >= 2 || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= frame_w) begin
      col_in = 0;
      row_in++;
    end
    if (!ready) return;
    // zero padding: taps outside the frame are skipped
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0; gy = 0;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && row_out == 0) continue;
        if (r == 2 && row_out + 1 >= frame_h) continue;
        for (int k = 0; k < 3; k++) begin
          if (k == 0 && col_out == 0) continue;
          if (k == 2 && col_out + 1 >= frame_w) continue;
          v = (win[r*3+k] >> (16 - 8*ch)) & 8'hFF;
          gx += v * KernX[r*3+k];
          gy += v * KernY[r*3+k];
        end
      end
      mag[ch] = rounded_root(gx * gx + gy * gy);
    end
    e.red = mag[0]; e.green = mag[1]; e.blue = mag[2];
    e.eol = col_out + 1 >= frame_w;
    e.eof = e.eol && row_out + 1 >= frame_h;
    edge_q.push_back(e);
    if (e.eof) clear_frame();
    else if (e.eol) begin
      col_out = 0;
      row_out++;
    end else col_out++;
  endfunction

  initial begin
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    frame_w = 1024;
    frame_h = 1;
    clear_frame();
    fail_count_o = 0;
    results_o = 0;
  end

  // Register writes restart the frame
  always @(posedge clk_i) begin
    if (rst_ni && psel && penable && pwrite && pready) begin
      if (paddr[2] == RegWidth) begin
        frame_w = pwdata[10:0];
        if (frame_w == 0) frame_w = 1;
        if (frame_w > LineDepth) frame_w = LineDepth;
      end else begin
        frame_h = pwdata[11:0];
        if (frame_h == 0) frame_h = 1;
      end
      clear_frame();
    end
  end

  // Input transactions
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata, s_axis_tuser);
  end

  // Output transactions
  always @(posedge clk_i) begin
    edge_pix_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_o++;
      if (edge_q.size() == 0) begin
        $display("%0t: unexpected result: tdata=%h last=%b user=%b", $time,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fail_count_o++;
      end else begin
        e = edge_q.pop_front();
        if (m_axis_tdata[7:0] !== e.red || m_axis_tdata[15:8] !== e.green ||
            m_axis_tdata[23:16] !== e.blue || m_axis_tlast !== e.eol ||
            m_axis_tuser !== e.eof) begin
          $display("%0t: result mismatch: expected rgb=%h/%h/%h eol=%b eof=%b", $time,
                   e.red, e.green, e.blue, e.eol, e.eof);
          $display("%0t:                  actual rgb=%h/%h/%h eol=%b eof=%b", $time,
                   m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tlast, m_axis_tuser);
          fail_count_o++;
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for sobel_edge_magnitude_rgb: drives frames, flush items and register
// writes with random idling, and gives the verdict. Depends on sem_checker and sem_pkg.
`timescale 1ns / 1ps
module tb_top import sem_pkg::*; ();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, results;
  int          pixels_sent, items_sent, frames_run;
  bit          quiet, long_hold;

  always #10 clk_i = ~clk_i;

  sobel_edge_magnitude_rgb dut (.*);

  sem_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  // Run limit
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk_i);
      end
    end
  end

  // One input transaction; called at a falling edge, returns at one
  task automatic send_pixel(input logic [23:0] data, input logic flush);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= flush;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait for all expected results, then for the pipeline to settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_pixel(input int style);
    case (style)
      1: return 24'h000000;
      2: return 24'hFFFFFF;
      3: return {24{$urandom_range(0, 1) == 1}} & 24'hFF00FF;
      default: return 24'($urandom());
    endcase
  endfunction

  // Full frame: pixels with occasional ignored flushes, then width+1 trailing items
  task automatic run_frame(input int w, input int h, input int style);
    int ew, eh;
    ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
    eh = (h == 0) ? 1 : h;
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
    for (int i = 0; i < ew * eh; i++) begin
      if ($urandom_range(0, 15) == 0) send_pixel(24'($urandom()), 1'b1);
      send_pixel(rand_pixel(style), 1'b0);
      pixels_sent++;
    end
    // trailing items: flush, or a pixel that counts as one
    for (int i = 0; i <= ew; i++) send_pixel(24'($urandom()), 1'($urandom_range(0, 1)));
    wait_drained();
    frames_run++;
  endtask

  initial begin
    int w, h;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: small frames with flat, saturated and mixed content
    run_frame(3, 3, 2);
    run_frame(1, 1, 2);
    run_frame(0, 0, 3);
    run_frame(2, 2, 1);
    // Out-of-range width, abandoned part way by the next register write
    reg_write(RegWidth, 32'h7FF);
    reg_write(RegHeight, 32'h1);
    for (int i = 0; i < 6; i++) send_pixel(24'h808080, 1'b0);
    wait_drained();
    // Tallest frame, abandoned part way by the next register write
    reg_write(RegWidth, 32'h1);
    reg_write(RegHeight, 32'hFFF);
    for (int i = 0; i < 6; i++) send_pixel(24'hFFFFFF, 1'b0);
    wait_drained();

    // Random frames; a long receiver hold-off on a busy frame early on
    while (items_sent < 1850) begin
      if (items_sent > 1600) quiet = 1'b1;
      if (frames_run == 8) begin
        long_hold = 1'b1;
        run_frame(12, 8, 0);
      end else begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
        run_frame(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
      end
    end
    wait_drained();

    $display("ran %0d frames, %0d transactions (%0d pixels), %0d result pixels checked",
             frames_run, items_sent, pixels_sent, results);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
src/sem_pkg.sv
src/sem_ram.sv
src/sem_front.sv
src/sem_fifo.sv
src/sem_back.sv
src/sobel_edge_magnitude_rgb.sv
dv/sem_checker.sv
dv/tb_top.sv
